// ===== rtl/msnb_pkg.sv =====
// Package for the multichannel slope notch biquad.
// Holds channel count, field widths and the payload structs; no dependencies.
package msnb_pkg;
  localparam int NUM_CHANNELS = 8;
  localparam int CH_W = 3;
  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVING = 2'd2;
  localparam int IN_W = 104;
  localparam int OUT_W = 40;

  typedef struct packed {
    logic signed [31:0] initial_value;
    logic use_initial;
    logic restart;
    logic [CH_W-1:0] channel;
    logic signed [31:0] corner_freq;
    logic signed [31:0] sample;
  } in_item_t;
endpackage

// ===== rtl/multichannel_slope_notch_biquad_top.sv =====
// Top level of the multichannel slope notch biquad: sequencer, history and
// coefficient store, shared multiplier and restoring divider. Uses msnb_pkg.
//
// A transaction passes, from acceptance to the result, through the coefficient
// products when the coefficients are recomputed (restart, or moving mode set): four
// products through one 32x32 multiplier; then the three numerator products
// (48-bit operands split into two 24-bit halves), then 128 steps of a
// one-bit-per-cycle restoring divider; a zero or negative divisor skips the divider.
// The block accepts a new input transaction once the previous result has been taken
// from the output register, which holds until taken. An out-of-range channel skips all steps.
module multichannel_slope_notch_biquad_top (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // sample[31:0], corner_freq[63:32], channel[66:64], restart[67],
  // use_initial[68], initial_value[100:69], zero fill
  input  logic [msnb_pkg::IN_W-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // filtered[31:0], next_channel[35:32], saturated[36], divide_error[37], zero fill
  output logic [msnb_pkg::OUT_W-1:0] out_tdata,
  input  logic cfg_we,
  input  logic [msnb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [msnb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import msnb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MUL, S_COEF, S_NUM, S_DIV, S_ROUND, S_WRITE, S_OUT
  } state_t;

  state_t state_r;
  logic [23:0] time_step_r;
  logic [15:0] damping_r;
  logic moving_r;

  logic signed [31:0] ih1_r [NUM_CHANNELS];
  logic signed [31:0] ih2_r [NUM_CHANNELS];
  logic signed [31:0] oh1_r [NUM_CHANNELS];
  logic signed [31:0] oh2_r [NUM_CHANNELS];
  logic signed [47:0] b2_r [NUM_CHANNELS];
  logic signed [47:0] a2_r [NUM_CHANNELS];
  logic signed [47:0] a1_r [NUM_CHANNELS];
  logic signed [47:0] a0_r [NUM_CHANNELS];

  in_item_t item_r;
  logic [IDX_W-1:0] ch_r;
  logic signed [31:0] x1_r, y1_r, y2_r;
  logic signed [47:0] cb2_r, ca2_r, ca1_r, ca0_r;
  logic [33:0] p_r;
  logic [4:0] step_r;
  logic [7:0] cnt_r;
  logic [63:0] ma_r;
  logic [31:0] mb_r;
  logic [63:0] prod_r;
  logic [127:0] acc_r;
  logic [127:0] num_r;
  logic [127:0] q_r;
  logic [48:0] rem_r;
  logic neg_r;
  logic [OUT_W-1:0] out_r;
  logic out_v_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [49:0] rem_sh;
  logic [48:0] dvs;
  logic [4:0] ch_full;
  logic in_range;
  logic signed [32:0] dx;
  logic [47:0] dq_w;
  logic [47:0] fourd;
  logic [128:0] qr;
  logic [31:0] y_w;
  logic sat_w;
  logic derr_w;

  in_item_t in_item;
  assign in_item = in_item_t'(in_tdata[$bits(in_item_t)-1:0]);

  assign in_tready = (state_r == S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;
  assign mul_a = ma_r[31:0];
  assign mul_b = mb_r;
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign ch_full = 5'(item_r.channel);
  assign in_range = ch_full < 5'(NUM_CHANNELS);
  assign dx = 33'(item_r.sample) - 33'(x1_r);
  assign dvs = {1'b0, ca2_r};
  assign rem_sh = {rem_r, num_r[127]};
  assign fourd = 48'(damping_r) << 14;
  assign dq_w = 48'((acc_r[63:0] + (prod_r << 32) + 64'h800) >> 12);
  assign qr = {1'b0, q_r} + 129'(((rem_r) >= (dvs - rem_r)) ? 1 : 0);

  always_comb begin
    derr_w = 1'b0;
    sat_w = 1'b0;
    y_w = 32'd0;
    if (ca2_r <= 0) begin
      derr_w = 1'b1;
    end else if (!neg_r) begin
      if (qr > 129'h7FFFFFFF) begin
        y_w = 32'h7FFFFFFF;
        sat_w = 1'b1;
      end else begin
        y_w = qr[31:0];
      end
    end else begin
      if (qr > 129'h80000000) begin
        y_w = 32'h80000000;
        sat_w = 1'b1;
      end else begin
        y_w = 32'(-qr[31:0]);
      end
    end
  end

  // signed product term: magnitude in ma/mb, sign applied on accumulate
  logic [47:0] mag_c;
  logic [32:0] mag_x;
  logic term_neg;
  logic signed [47:0] cur_c;
  logic signed [32:0] cur_x;
  always_comb begin
    unique case (step_r[4:3])
      2'd0: begin cur_c = cb2_r; cur_x = dx; end
      2'd1: begin cur_c = ca1_r; cur_x = 33'(y1_r); end
      default: begin cur_c = ca0_r; cur_x = 33'(y2_r); end
    endcase
    mag_c = cur_c[47] ? 48'(-cur_c) : 48'(cur_c);
    mag_x = cur_x[32] ? 33'(-cur_x) : 33'(cur_x);
    // b2 term adds, a1 and a0 terms subtract
    term_neg = (cur_c[47] ^ cur_x[32]) ^ (step_r[4:3] != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      time_step_r <= 24'd167772;
      damping_r <= 16'd4096;
      moving_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ih1_r[i] <= '0; ih2_r[i] <= '0; oh1_r[i] <= '0; oh2_r[i] <= '0;
        b2_r[i] <= '0; a2_r[i] <= '0; a1_r[i] <= '0; a0_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_TIME_STEP: time_step_r <= cfg_data;
          REG_DAMPING: damping_r <= cfg_data[15:0];
          REG_MOVING: moving_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            item_r <= in_item;
            ch_r <= IDX_W'(in_item.channel);
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (!in_range) begin
            out_r <= OUT_W'({4'(ch_full + 5'd1), 32'd0});
            out_v_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            if (item_r.restart) begin
              x1_r <= item_r.use_initial ? item_r.initial_value : item_r.sample;
              y1_r <= item_r.use_initial ? item_r.initial_value : item_r.sample;
              y2_r <= item_r.use_initial ? item_r.initial_value : item_r.sample;
            end else begin
              x1_r <= ih1_r[ch_r];
              y1_r <= oh1_r[ch_r];
              y2_r <= oh2_r[ch_r];
            end
            cb2_r <= b2_r[ch_r]; ca2_r <= a2_r[ch_r];
            ca1_r <= a1_r[ch_r]; ca0_r <= a0_r[ch_r];
            step_r <= '0;
            if (item_r.restart || moving_r) begin
              // DT * w
              ma_r <= 64'(time_step_r);
              mb_r <= item_r.corner_freq[31] ? 32'd0 : 32'(item_r.corner_freq);
              state_r <= S_MUL;
            end else begin
              acc_r <= '0;
              state_r <= S_NUM;
            end
          end
        end
        S_MUL: begin
          prod_r <= mul_p;
          state_r <= S_COEF;
        end
        S_COEF: begin
          unique case (step_r)
            5'd0: begin
              p_r <= ((prod_r + 64'h8000) >> 16) > 64'hFFFFFFFF ? 34'hFFFFFFFF :
                     34'((prod_r + 64'h8000) >> 16);
              ma_r <= 64'(((prod_r + 64'h8000) >> 16) > 64'hFFFFFFFF ? 64'hFFFFFFFF :
                     ((prod_r + 64'h8000) >> 16));
              mb_r <= ((prod_r + 64'h8000) >> 16) > 64'hFFFFFFFF ? 32'hFFFFFFFF :
                      32'((prod_r + 64'h8000) >> 16);
              step_r <= 5'd1;
              state_r <= S_MUL;
            end
            5'd1: begin
              // p^2 rounded to Q.24, then times D in two halves
              ma_r <= 64'((prod_r >> 24) + 64'(prod_r[23]));
              mb_r <= 32'(damping_r);
              step_r <= 5'd2;
              state_r <= S_MUL;
            end
            5'd2: begin
              acc_r <= 128'(prod_r);
              ma_r <= 64'(ma_r[63:32]);
              step_r <= 5'd3;
              state_r <= S_MUL;
            end
            default: begin
              cb2_r <= 48'(p_r << 1);
              ca2_r <= 48'(dq_w + 48'(p_r << 1) + fourd);
              ca1_r <= 48'((dq_w << 1) - (fourd << 1));
              ca0_r <= 48'(dq_w - 48'(p_r << 1) + fourd);
              acc_r <= '0;
              step_r <= '0;
              state_r <= S_NUM;
            end
          endcase
        end
        S_NUM: begin
          // steps: 0 issues low coefficient half, 1 collects it and issues high half, 2 collects, 3 accumulates
          unique case (step_r[1:0])
            2'd0: begin ma_r <= 64'(mag_c[23:0]); mb_r <= mag_x[31:0];
              prod_r <= 64'(mag_x[32]) << 32; step_r <= step_r + 5'd1; end
            2'd1: begin
              num_r <= 128'(mul_p) +
                       (prod_r[32] ? (128'(mag_c[23:0]) << 32) : 128'd0);
              ma_r <= 64'(mag_c[47:24]);
              step_r <= step_r + 5'd1;
            end
            2'd2: begin
              num_r <= num_r + ((128'(mul_p) +
                       (prod_r[32] ? (128'(mag_c[47:24]) << 32) : 128'd0)) << 24);
              step_r <= step_r + 5'd1;
            end
            default: begin
              acc_r <= term_neg ? acc_r - num_r : acc_r + num_r;
              if (step_r[4:3] == 2'd2) begin
                neg_r <= (term_neg ? acc_r - num_r : acc_r + num_r) >> 127 != 0;
                num_r <= ((term_neg ? acc_r - num_r : acc_r + num_r) >> 127 != 0) ?
                         -(term_neg ? acc_r - num_r : acc_r + num_r) :
                         (term_neg ? acc_r - num_r : acc_r + num_r);
                q_r <= '0;
                rem_r <= '0;
                cnt_r <= '0;
                state_r <= (ca2_r <= 0) ? S_ROUND : S_DIV;
              end else begin
                step_r <= {step_r[4:3] + 2'd1, 3'd0};
              end
            end
          endcase
        end
        S_DIV: begin
          if (rem_sh >= 50'(dvs)) begin
            rem_r <= 49'(rem_sh - 50'(dvs));
            q_r <= {q_r[126:0], 1'b1};
          end else begin
            rem_r <= rem_sh[48:0];
            q_r <= {q_r[126:0], 1'b0};
          end
          num_r <= {num_r[126:0], 1'b0};
          cnt_r <= cnt_r + 8'd1;
          if (cnt_r == 8'd127) state_r <= S_ROUND;
        end
        S_ROUND: begin
          out_r <= OUT_W'({derr_w, sat_w, 4'(ch_full + 5'd1), y_w});
          ih2_r[ch_r] <= x1_r;
          ih1_r[ch_r] <= item_r.sample;
          oh2_r[ch_r] <= y1_r;
          oh1_r[ch_r] <= y_w;
          b2_r[ch_r] <= cb2_r; a2_r[ch_r] <= ca2_r;
          a1_r[ch_r] <= ca1_r; a0_r[ch_r] <= ca0_r;
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== test/msnb_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the multichannel slope notch biquad: watches the input, result and
// register ports, predicts every result with its own filter arithmetic and compares.
// Depends on msnb_pkg.
module msnb_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tready,
  input  logic [msnb_pkg::IN_W-1:0] in_tdata,
  input  logic out_tvalid,
  input  logic out_tready,
  input  logic [msnb_pkg::OUT_W-1:0] out_tdata,
  input  logic cfg_we,
  input  logic [msnb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [msnb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int errors,
  output int pending,
  output int results_seen,
  output int saturations,
  output int div_errors
);
  import msnb_pkg::*;

  typedef struct packed {
    logic divide_error;
    logic saturated;
    logic [3:0] next_channel;
    logic signed [31:0] filtered;
  } filter_out_t;

  filter_out_t expected_q[$];

  logic [23:0] dt_q024;
  logic [15:0] damp_q412;
  logic moving;

  longint hist_x1[NUM_CHANNELS];
  longint hist_x2[NUM_CHANNELS];
  longint hist_y1[NUM_CHANNELS];
  longint hist_y2[NUM_CHANNELS];
  longint c_b2[NUM_CHANNELS];
  longint c_a2[NUM_CHANNELS];
  longint c_a1[NUM_CHANNELS];
  longint c_a0[NUM_CHANNELS];

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  function automatic void load_coefs(input int ch, input logic signed [31:0] corner);
    logic [63:0] w, p, p24, sq, q24, dq, fourd;
    w = corner[31] ? 64'd0 : {32'd0, corner};
    p = {40'd0, dt_q024} * w;
    p24 = (p + 64'h8000) >> 16;
    if (p24 > 64'hFFFF_FFFF) p24 = 64'hFFFF_FFFF;
    sq = p24 * p24;
    q24 = (sq >> 24) + ((sq >> 23) & 64'd1);
    dq = ({48'd0, damp_q412} * q24 + 64'h800) >> 12;
    fourd = {48'd0, damp_q412} << 14;
    c_b2[ch] = longint'(2 * p24);
    c_a2[ch] = longint'(dq + 2 * p24 + fourd);
    c_a1[ch] = longint'(2 * dq) - longint'(2 * fourd);
    c_a0[ch] = longint'(dq) - longint'(2 * p24) + longint'(fourd);
  endfunction

  function automatic filter_out_t filter_step(input in_item_t it);
    filter_out_t r;
    int ch;
    longint x, seed;
    logic signed [127:0] num, tb2, tdx, ta1, ty1, ta0, ty2;
    logic [127:0] mag, quo, rem, d;
    logic neg;
    longint y;
    ch = int'(it.channel);
    x = longint'(it.sample);
    seed = it.use_initial ? longint'(it.initial_value) : x;
    r = '0;
    r.next_channel = {1'b0, it.channel} + 4'd1;
    if (ch >= NUM_CHANNELS) return r;
    if (it.restart) begin
      hist_x1[ch] = seed; hist_x2[ch] = seed;
      hist_y1[ch] = seed; hist_y2[ch] = seed;
    end
    if (it.restart || moving) load_coefs(ch, it.corner_freq);
    y = 0;
    if (c_a2[ch] <= 0) begin
      r.divide_error = 1'b1;
    end else begin
      tb2 = c_b2[ch]; tdx = x - hist_x1[ch];
      ta1 = c_a1[ch]; ty1 = hist_y1[ch];
      ta0 = c_a0[ch]; ty2 = hist_y2[ch];
      num = tb2 * tdx - ta1 * ty1 - ta0 * ty2;
      neg = num[127];
      mag = neg ? -num : num;
      d = 128'(c_a2[ch]);
      quo = mag / d;
      rem = mag % d;
      if (rem >= d - rem) quo = quo + 1;
      if (!neg) begin
        if (quo > 128'h7FFF_FFFF) begin
          y = 64'sh7FFF_FFFF; r.saturated = 1'b1;
        end else begin
          y = longint'(quo[63:0]);
        end
      end else begin
        if (quo > 128'h8000_0000) begin
          y = -64'sh8000_0000; r.saturated = 1'b1;
        end else begin
          y = -longint'(quo[63:0]);
        end
      end
    end
    r.filtered = y[31:0];
    hist_x2[ch] = hist_x1[ch];
    hist_x1[ch] = x;
    hist_y2[ch] = hist_y1[ch];
    hist_y1[ch] = y;
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    saturations = 0;
    div_errors = 0;
  end

  always @(posedge clk) begin
    filter_out_t got, want;
    if (!rst_n) begin
      dt_q024 = 24'd167772;
      damp_q412 = 16'd4096;
      moving = 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        hist_x1[i] = 0; hist_x2[i] = 0; hist_y1[i] = 0; hist_y2[i] = 0;
        c_b2[i] = 0; c_a2[i] = 0; c_a1[i] = 0; c_a0[i] = 0;
      end
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TIME_STEP: dt_q024 = cfg_data[23:0];
          REG_DAMPING: damp_q412 = cfg_data[15:0];
          REG_MOVING: moving = cfg_data[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[37:0];
        results_seen++;
        if (got.saturated) saturations++;
        if (got.divide_error) div_errors++;
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result %h", out_tdata));
        end else begin
          want = expected_q.pop_front();
          if (got.filtered !== want.filtered)
            report($sformatf("filtered %h, want %h", got.filtered, want.filtered));
          if (got.next_channel !== want.next_channel)
            report($sformatf("next_channel %0d, want %0d", got.next_channel,
                             want.next_channel));
          if (got.saturated !== want.saturated)
            report($sformatf("saturated %b, want %b", got.saturated, want.saturated));
          if (got.divide_error !== want.divide_error)
            report($sformatf("divide_error %b, want %b", got.divide_error,
                             want.divide_error));
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(filter_step(in_item_t'(in_tdata[$bits(in_item_t)-1:0])));
    end
    pending = expected_q.size();
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for multichannel_slope_notch_biquad_top: clock, reset, register
// writes and stream stimulus with random idling; checking lives in msnb_checker.
// Depends on msnb_pkg, msnb_checker and the block.
module testbench;
  import msnb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors, pending, results_seen, saturations, div_errors;
  int send_idle_pct;
  int stall_pct;
  int sent;

  multichannel_slope_notch_biquad_top uut (.*);

  msnb_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("multichannel_slope_notch_biquad_top test failed");
    $finish;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send(input logic signed [31:0] smp, input logic signed [31:0] corner,
                      input logic [2:0] ch, input logic rst_flag, input logic use_init,
                      input logic signed [31:0] init_val);
    in_item_t it;
    int gap;
    it = '{initial_value: init_val, use_initial: use_init, restart: rst_flag,
           channel: ch, corner_freq: corner, sample: smp};
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = IN_W'(it);
    do @(posedge clk); while (!in_tready);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic logic [31:0] pick_corner();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom;
      2: return 32'd0;
      default: return $urandom_range(0, 1 << 23);
    endcase
  endfunction

  task automatic random_items(input int count);
    logic [2:0] ch;
    for (int n = 0; n < count; n++) begin
      ch = 3'($urandom_range(NUM_CHANNELS - 1));
      send(pick_sample(), pick_corner(), ch, $urandom_range(99) < 15,
           1'($urandom_range(1)), $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_TIME_STEP;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    out_tready = 1'b0;
    sent = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // coefficients never loaded: divide error
    send(32'h0001_0000, 32'h0010_0000, 3'd0, 1'b0, 1'b0, 32'd0);
    send(32'h0001_0000, 32'h0010_0000, 3'd7, 1'b0, 1'b0, 32'd0);
    for (int c = 0; c < NUM_CHANNELS; c++)
      send(32'h0000_8000, 32'h0010_0000 * (c + 1), 3'(c), 1'b1, c[0], 32'h0002_0000);
    send(32'h7FFF_FFFF, 32'h0001_0000, 3'd1, 1'b0, 1'b0, 32'd0);
    send(32'h8000_0000, 32'h0001_0000, 3'd1, 1'b0, 1'b0, 32'd0);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 3'd2, 1'b1, 1'b1, 32'h8000_0000);
    send(32'h8000_0000, 32'h7FFF_FFFF, 3'd2, 1'b0, 1'b0, 32'd0);
    send(32'h1234_5678, 32'h8000_0000, 3'd3, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 32'h7FFF_FFFF);
    send(32'd0, 32'd0, 3'd5, 1'b1, 1'b0, 32'd0);
    drain();

    write_reg(REG_DAMPING, 24'd0);
    write_reg(REG_MOVING, 24'hFFFFFF);
    write_reg(REG_UNUSED, 24'h5A5A5A);
    send(32'h0001_0000, 32'd0, 3'd6, 1'b1, 1'b0, 32'd0);
    send(32'h0001_0000, 32'h8765_4321, 3'd6, 1'b0, 1'b0, 32'd0);
    send(32'h0001_0000, 32'h0008_0000, 3'd6, 1'b0, 1'b0, 32'd0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 81; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 81; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      for (int s = 0; s < 4; s++) begin
        drain();
        case ((phase * 4 + s) % 5)
          0: write_reg(REG_TIME_STEP, 24'hFFFFFF);
          1: write_reg(REG_TIME_STEP, 24'd0);
          2: write_reg(REG_TIME_STEP, 24'($urandom_range(1, 24'hFFFFFF)));
          3: write_reg(REG_TIME_STEP, 24'd167772);
          default: write_reg(REG_TIME_STEP, 24'($urandom_range(1, 1 << 16)));
        endcase
        case (s)
          0: write_reg(REG_DAMPING, 24'h00FFFF);
          1: write_reg(REG_DAMPING, 24'h0);
          2: write_reg(REG_DAMPING, 24'($urandom));
          default: write_reg(REG_DAMPING, 24'd4096);
        endcase
        write_reg(REG_MOVING, 24'($urandom_range(1)));
        // restart every instance so the new setting takes hold
        for (int c = 0; c < NUM_CHANNELS; c++)
          send(pick_sample(), pick_corner(), 3'(c), 1'b1, 1'($urandom_range(1)),
               $urandom);
        random_items(110);
      end
      // stretch without idling inside each phase
      send_idle_pct = 0;
      stall_pct = 0;
      random_items(20);
    end

    drain();
    $display("%0d transactions sent, %0d results checked over 4 idling phases", sent,
             results_seen);
    $display("%0d saturated, %0d divide errors, %0d mismatches", saturations, div_errors,
             errors);
    if (errors == 0) begin
      $display("multichannel_slope_notch_biquad_top test passed");
    end else begin
      $display("multichannel_slope_notch_biquad_top test failed");
    end
    $finish;
  end
endmodule
